### src/fqrm_pkg.sv
// Shared types, codes and field widths of the FIFO queue with remove by id.
package fqrm_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam int CLIENT_ID_W   = 16;
  localparam int COUNT_FIELD_W = 5;
  localparam int IN_TDATA_W    = 16;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 24;
  localparam int OUT_PAD_W     = OUT_TDATA_W - (1 + CLIENT_ID_W + COUNT_FIELD_W + 1);

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENQ,
    OP_FLUSH,
    OP_RD,
    OP_DEQ_DONE,
    OP_IDX_INC,
    OP_SH_RD,
    OP_SH_WR,
    OP_RM_DONE,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic match;
    logic scan_last;
    logic shift_last;
  } dp_status_t;

endpackage

### src/fifo_queue_with_remove_by_id_unit.sv
// Top level of the FIFO queue of client ids with remove by id, joining controller and datapath.
// Sequence: enqueue, flush, a failing dequeue and a remove on an empty queue pass from dispatch
// straight to the finishing state; a successful dequeue first waits for the entry read; a remove
// on a non-empty queue scans the entries and, on a hit, closes the gap before it finishes.
// One command at a time: the next item is taken only after the previous result is registered.
// The entry memory is single-port, with one access per sequencer step.
// Reset (rst_n low at a clock edge) empties the queue; entry contents stay undefined until written.
module fifo_queue_with_remove_by_id_unit import fqrm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Command channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] client_id
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] command
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] ok, [16:1] id_out, [21:17] entry_count,
                                             // [22] is_empty, [23] zero
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The controller steps each command through the datapath: it latches the item, dispatches on
  // the command code, walks the entries for a remove and then loads the result register. The
  // result register frees the controller to take a new item while a result waits downstream.
  fqrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_status  (dp_status),
    .dp_cmd     (dp_cmd)
  );

  // The datapath keeps the queue as a ring in memory: the head pointer moves on a dequeue, and a
  // remove copies every later entry one slot toward the head before the count drops.
  fqrm_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .out_tdata (out_tdata)
  );

endmodule

### src/fqrm_dpath.sv
// Datapath of the queue: entry memory, head and count registers, scan index and result registers.
module fqrm_dpath import fqrm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  dp_cmd_t                dp_cmd,
  output dp_status_t             dp_status,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Physical slot of a logical position: the head plus an offset, wrapped once.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [ID_BITS-1:0]       store_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       rdata_r;

  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]       id_r, id_nxt;
  logic                     res_ok_r, res_ok_nxt;
  logic [ID_BITS-1:0]       res_id_r, res_id_nxt;

  logic                     out_ok_r, out_ok_nxt;
  logic [CLIENT_ID_W-1:0]   out_id_r, out_id_nxt;
  logic [COUNT_FIELD_W-1:0] out_count_r, out_count_nxt;
  logic                     out_empty_r, out_empty_nxt;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [ID_BITS-1:0]       wr_data;
  logic [CW:0]              idx_p1, idx_p2;

  assign wr_en   = (dp_cmd.op == OP_ENQ) || (dp_cmd.op == OP_SH_WR);
  assign rd_en   = (dp_cmd.op == OP_RD) || (dp_cmd.op == OP_SH_RD);
  assign wr_addr = (dp_cmd.op == OP_ENQ) ? wrap_add(head_r, count_r[AW-1:0])
                                         : wrap_add(head_r, idx_r);
  assign wr_data = (dp_cmd.op == OP_ENQ) ? id_r : rdata_r;
  assign rd_addr = (dp_cmd.op == OP_SH_RD) ? wrap_add(head_r, idx_r + AW'(1))
                                           : wrap_add(head_r, idx_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= store_r[rd_addr];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    res_ok_nxt    = res_ok_r;
    res_id_nxt    = res_id_r;
    out_ok_nxt    = out_ok_r;
    out_id_nxt    = out_id_r;
    out_count_nxt = out_count_r;
    out_empty_nxt = out_empty_r;
    case (dp_cmd.op)
      OP_LOAD: begin
        cmd_nxt    = cmd_t'(in_tuser);
        id_nxt     = ID_BITS'(in_tdata);
        idx_nxt    = '0;
        res_ok_nxt = 1'b0;
        res_id_nxt = '0;
      end
      OP_ENQ: begin
        count_nxt  = count_r + CW'(1);
        res_ok_nxt = 1'b1;
      end
      OP_FLUSH: begin
        count_nxt  = '0;
        head_nxt   = '0;
        res_ok_nxt = 1'b1;
      end
      OP_DEQ_DONE: begin
        res_id_nxt = rdata_r;
        head_nxt   = wrap_add(head_r, AW'(1));
        count_nxt  = count_r - CW'(1);
        res_ok_nxt = 1'b1;
      end
      OP_IDX_INC, OP_SH_WR: begin
        idx_nxt = idx_r + AW'(1);
      end
      OP_RM_DONE: begin
        count_nxt  = count_r - CW'(1);
        res_ok_nxt = 1'b1;
      end
      OP_PUBLISH: begin
        out_ok_nxt    = res_ok_r;
        out_id_nxt    = CLIENT_ID_W'(res_id_r);
        out_count_nxt = COUNT_FIELD_W'(count_r);
        out_empty_nxt = (count_r == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    res_ok_r    <= res_ok_nxt;
    res_id_r    <= res_id_nxt;
    out_ok_r    <= out_ok_nxt;
    out_id_r    <= out_id_nxt;
    out_count_r <= out_count_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign idx_p1 = (CW+1)'(idx_r) + (CW+1)'(1);
  assign idx_p2 = (CW+1)'(idx_r) + (CW+1)'(2);

  assign dp_status.cmd        = cmd_r;
  assign dp_status.full       = (count_r == CW'(QUEUE_DEPTH));
  assign dp_status.empty      = (count_r == '0);
  assign dp_status.match      = (rdata_r == id_r);
  assign dp_status.scan_last  = (idx_p1 == (CW+1)'(count_r));
  assign dp_status.shift_last = (idx_p2 == (CW+1)'(count_r));

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_empty_r, out_count_r, out_id_r, out_ok_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == OP_ENQ) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("enqueue did not grow the count by one");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == OP_FLUSH) |=> (count_r == '0))
    else $error("flush left entries behind");

endmodule

### src/fqrm_ctrl.sv
// Controller of the queue: sequences each command over the datapath and runs both handshakes.
module fqrm_ctrl import fqrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DEQ_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RM_END,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    dp_cmd.op     = OP_NONE;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dp_cmd.op = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (dp_status.cmd)
          CMD_ENQ: begin
            if (!dp_status.full) begin
              dp_cmd.op = OP_ENQ;
            end
            state_nxt = S_FIN;
          end
          CMD_DEQ: begin
            if (dp_status.empty) begin
              state_nxt = S_FIN;
            end else begin
              dp_cmd.op = OP_RD;
              state_nxt = S_DEQ_WAIT;
            end
          end
          CMD_REMOVE: begin
            if (dp_status.empty) begin
              state_nxt = S_FIN;
            end else begin
              dp_cmd.op = OP_RD;
              state_nxt = S_SCAN_CMP;
            end
          end
          CMD_FLUSH: begin
            dp_cmd.op = OP_FLUSH;
            state_nxt = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_DEQ_WAIT: begin
        dp_cmd.op = OP_DEQ_DONE;
        state_nxt = S_FIN;
      end
      S_SCAN_RD: begin
        dp_cmd.op = OP_RD;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (dp_status.match) begin
          if (dp_status.scan_last) begin
            dp_cmd.op = OP_RM_DONE;
            state_nxt = S_FIN;
          end else begin
            dp_cmd.op = OP_SH_RD;
            state_nxt = S_SH_WR;
          end
        end else if (dp_status.scan_last) begin
          state_nxt = S_FIN;
        end else begin
          dp_cmd.op = OP_IDX_INC;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        dp_cmd.op = OP_SH_RD;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        dp_cmd.op = OP_SH_WR;
        state_nxt = dp_status.shift_last ? S_RM_END : S_SH_RD;
      end
      S_RM_END: begin
        dp_cmd.op = OP_RM_DONE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          dp_cmd.op     = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == OP_PUBLISH) |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before it was taken");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the finishing state");

endmodule
